// ===== sv/srod_pkg.sv =====
// ----------------------------------------------------------------------------
// srod_pkg
// shared constants, types and helpers of the sector range obstacle detector
// ----------------------------------------------------------------------------
package srod_pkg;

  // field and state widths
  localparam int RANGE_BITS  = 16;
  localparam int ANGLE_BITS  = 8;
  localparam int THR_BITS    = 16;
  localparam int WIN_BITS    = 8;
  localparam int SUM_BITS    = 24;
  localparam int CNT_BITS    = 8;
  localparam int TOTAL_BITS  = CNT_BITS + 2;
  localparam int ADD_BITS    = ((RANGE_BITS > SUM_BITS) ? RANGE_BITS : SUM_BITS) + 1;

  localparam logic [SUM_BITS-1:0] SUM_MAX = {SUM_BITS{1'b1}};

  // queue sizes (powers of two)
  localparam int MID_DEPTH    = 2;
  localparam int MID_PTR_BITS = $clog2(MID_DEPTH);
  localparam int MID_CNT_BITS = $clog2(MID_DEPTH + 1);
  localparam int OUT_DEPTH    = 4;
  localparam int OUT_PTR_BITS = $clog2(OUT_DEPTH);
  localparam int OUT_CNT_BITS = $clog2(OUT_DEPTH + 1);

  // configuration port
  localparam int CFG_ADDR_BITS = 4;
  localparam int CFG_DATA_BITS = 32;

  localparam logic [ANGLE_BITS-1:0] FRONT_LOW_RST  = ANGLE_BITS'(95);
  localparam logic [ANGLE_BITS-1:0] FRONT_HIGH_RST = ANGLE_BITS'(105);
  localparam logic [THR_BITS-1:0]   THRESHOLD_RST  = THR_BITS'(1000);
  localparam logic [WIN_BITS-1:0]   WINDOW_RST     = WIN_BITS'(100);

  typedef enum logic [1:0] {
    REG_FRONT_LOW  = 2'd0,
    REG_FRONT_HIGH = 2'd1,
    REG_THRESHOLD  = 2'd2,
    REG_WINDOW     = 2'd3
  } reg_idx_t;

  typedef enum logic [1:0] {
    SECT_RIGHT = 2'd0,
    SECT_FRONT = 2'd1,
    SECT_LEFT  = 2'd2
  } sector_t;

  typedef struct packed {
    logic [ANGLE_BITS-1:0] front_low;
    logic [ANGLE_BITS-1:0] front_high;
    logic [THR_BITS-1:0]   threshold;
    logic [WIN_BITS-1:0]   window;
  } cfg_t;

  // classified sample handed from front to back
  typedef struct packed {
    sector_t               sector;
    logic [RANGE_BITS-1:0] range;
  } mid_item_t;

  // window totals captured at window end
  typedef struct packed {
    logic [SUM_BITS-1:0] right_sum;
    logic [SUM_BITS-1:0] left_sum;
    logic [SUM_BITS-1:0] front_sum;
    logic [CNT_BITS-1:0] right_cnt;
    logic [CNT_BITS-1:0] left_cnt;
    logic [CNT_BITS-1:0] front_cnt;
  } win_t;

  typedef struct packed {
    logic [SUM_BITS-1:0] right_lim;
    logic [SUM_BITS-1:0] left_lim;
    logic [SUM_BITS-1:0] front_lim;
  } lim_t;

  typedef struct packed {
    logic right;
    logic left;
    logic front;
  } flags_t;

  // saturating accumulate of one sample into a sector sum
  function automatic logic [SUM_BITS-1:0] sat_add(input logic [SUM_BITS-1:0]   sum,
                                                  input logic [RANGE_BITS-1:0] rng);
    logic [ADD_BITS-1:0] s;
    s = ADD_BITS'(sum) + ADD_BITS'(rng);
    if (s > ADD_BITS'(SUM_MAX)) begin
      sat_add = SUM_MAX;
    end else begin
      sat_add = s[SUM_BITS-1:0];
    end
  endfunction

endpackage

// ===== sv/srod_front.sv =====
// ----------------------------------------------------------------------------
// srod_front
// accepts samples and sorts each one into the right, front or left sector
// ----------------------------------------------------------------------------
module srod_front (
  input  logic                           clk,
  input  logic                           rst_n,
  input  srod_pkg::cfg_t                 cfg,
  input  logic                           push,
  output logic                           full,
  input  logic [srod_pkg::ANGLE_BITS-1:0] scan_angle,
  input  logic [srod_pkg::RANGE_BITS-1:0] range_value,
  output logic                           mid_push,
  input  logic                           mid_full,
  output srod_pkg::mid_item_t            mid_item
);

  logic                v_r;
  logic                v_nxt;
  srod_pkg::mid_item_t item_r;
  srod_pkg::mid_item_t item_nxt;
  logic                accept;
  srod_pkg::sector_t   sector;

  // sector decision: below band is right, inside inclusive is front, else left
  always_comb begin
    priority if (scan_angle < cfg.front_low) begin
      sector = srod_pkg::SECT_RIGHT;
    end else if (scan_angle <= cfg.front_high) begin
      sector = srod_pkg::SECT_FRONT;
    end else begin
      sector = srod_pkg::SECT_LEFT;
    end
  end

  // holding stage in front of the queue
  assign mid_push = v_r && !mid_full;
  assign full     = v_r && mid_full;
  assign accept   = push && !full;
  assign mid_item = item_r;

  always_comb begin
    v_nxt    = accept || (v_r && mid_full);
    item_nxt = item_r;
    if (accept) begin
      item_nxt.sector = sector;
      item_nxt.range  = range_value;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else begin
      v_r <= v_nxt;
    end
    item_r <= item_nxt;
  end

endmodule

// ===== sv/srod_mid_fifo.sv =====
// ----------------------------------------------------------------------------
// srod_mid_fifo
// short queue of classified items between the front and the back
// ----------------------------------------------------------------------------
module srod_mid_fifo (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                wr_en,
  input  srod_pkg::mid_item_t wr_item,
  output logic                is_full,
  input  logic                rd_en,
  output logic                rd_valid,
  output srod_pkg::mid_item_t rd_item
);

  srod_pkg::mid_item_t                  mem_r [srod_pkg::MID_DEPTH];
  logic [srod_pkg::MID_PTR_BITS-1:0]    wr_ptr_r;
  logic [srod_pkg::MID_PTR_BITS-1:0]    wr_ptr_nxt;
  logic [srod_pkg::MID_PTR_BITS-1:0]    rd_ptr_r;
  logic [srod_pkg::MID_PTR_BITS-1:0]    rd_ptr_nxt;
  logic [srod_pkg::MID_CNT_BITS-1:0]    cnt_r;
  logic [srod_pkg::MID_CNT_BITS-1:0]    cnt_nxt;
  logic                                 do_wr;
  logic                                 do_rd;

  assign is_full  = (cnt_r == srod_pkg::MID_CNT_BITS'(srod_pkg::MID_DEPTH));
  assign rd_valid = (cnt_r != '0);
  assign rd_item  = mem_r[rd_ptr_r];
  assign do_wr    = wr_en && !is_full;
  assign do_rd    = rd_en && rd_valid;

  // pointer and occupancy update
  always_comb begin
    wr_ptr_nxt = do_wr ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = do_rd ? rd_ptr_r + 1'b1 : rd_ptr_r;
    cnt_nxt    = cnt_r + srod_pkg::MID_CNT_BITS'(do_wr) - srod_pkg::MID_CNT_BITS'(do_rd);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
    if (do_wr) begin
      mem_r[wr_ptr_r] <= wr_item;
    end
  end

endmodule

// ===== sv/srod_back.sv =====
// ----------------------------------------------------------------------------
// srod_back
// sector accumulators, window end detection, mean test and result queue
// ----------------------------------------------------------------------------
module srod_back (
  input  logic                clk,
  input  logic                rst_n,
  input  srod_pkg::cfg_t      cfg,
  input  logic                mid_valid,
  input  srod_pkg::mid_item_t mid_item,
  output logic                mid_pop,
  output logic                empty,
  input  logic                pop,
  output srod_pkg::flags_t    flags
);

  // accumulators
  logic [srod_pkg::SUM_BITS-1:0] right_sum_r, right_sum_nxt;
  logic [srod_pkg::SUM_BITS-1:0] left_sum_r,  left_sum_nxt;
  logic [srod_pkg::SUM_BITS-1:0] front_sum_r, front_sum_nxt;
  logic [srod_pkg::CNT_BITS-1:0] right_cnt_r, right_cnt_nxt;
  logic [srod_pkg::CNT_BITS-1:0] left_cnt_r,  left_cnt_nxt;
  logic [srod_pkg::CNT_BITS-1:0] front_cnt_r, front_cnt_nxt;
  logic [srod_pkg::TOTAL_BITS-1:0] total;
  logic                            win_end;
  srod_pkg::win_t                  upd;

  // result pipeline
  logic           s1_v_r, s1_v_nxt;
  srod_pkg::win_t s1_win_r;
  logic           s2_v_r;
  srod_pkg::win_t s2_win_r;
  srod_pkg::lim_t s2_lim_r;
  srod_pkg::lim_t lim;
  srod_pkg::flags_t res;

  // result queue
  srod_pkg::flags_t                  q_r [srod_pkg::OUT_DEPTH];
  logic [srod_pkg::OUT_PTR_BITS-1:0] q_wr_r, q_rd_r;
  logic [srod_pkg::OUT_CNT_BITS-1:0] q_cnt_r, q_cnt_nxt;
  logic [srod_pkg::OUT_CNT_BITS:0]   committed;
  logic                              q_pop;

  // take an item only while the result queue can hold everything in flight
  assign committed = (srod_pkg::OUT_CNT_BITS + 1)'(q_cnt_r)
                   + (srod_pkg::OUT_CNT_BITS + 1)'(s1_v_r)
                   + (srod_pkg::OUT_CNT_BITS + 1)'(s2_v_r);
  assign mid_pop   = mid_valid
                   && (committed < (srod_pkg::OUT_CNT_BITS + 1)'(srod_pkg::OUT_DEPTH));

  // add the sample into its sector
  always_comb begin
    upd.right_sum = right_sum_r;
    upd.left_sum  = left_sum_r;
    upd.front_sum = front_sum_r;
    upd.right_cnt = right_cnt_r;
    upd.left_cnt  = left_cnt_r;
    upd.front_cnt = front_cnt_r;
    unique case (mid_item.sector)
      srod_pkg::SECT_RIGHT: begin
        upd.right_sum = srod_pkg::sat_add(right_sum_r, mid_item.range);
        upd.right_cnt = right_cnt_r + 1'b1;
      end
      srod_pkg::SECT_FRONT: begin
        upd.front_sum = srod_pkg::sat_add(front_sum_r, mid_item.range);
        upd.front_cnt = front_cnt_r + 1'b1;
      end
      srod_pkg::SECT_LEFT: begin
        upd.left_sum = srod_pkg::sat_add(left_sum_r, mid_item.range);
        upd.left_cnt = left_cnt_r + 1'b1;
      end
      default: begin
      end
    endcase
    total   = srod_pkg::TOTAL_BITS'(upd.right_cnt) + srod_pkg::TOTAL_BITS'(upd.left_cnt)
            + srod_pkg::TOTAL_BITS'(upd.front_cnt);
    win_end = (total >= srod_pkg::TOTAL_BITS'(cfg.window));
  end

  // accumulator next state: clear at window end
  always_comb begin
    right_sum_nxt = right_sum_r;
    left_sum_nxt  = left_sum_r;
    front_sum_nxt = front_sum_r;
    right_cnt_nxt = right_cnt_r;
    left_cnt_nxt  = left_cnt_r;
    front_cnt_nxt = front_cnt_r;
    s1_v_nxt      = 1'b0;
    if (mid_pop) begin
      if (win_end) begin
        right_sum_nxt = '0;
        left_sum_nxt  = '0;
        front_sum_nxt = '0;
        right_cnt_nxt = '0;
        left_cnt_nxt  = '0;
        front_cnt_nxt = '0;
        s1_v_nxt      = 1'b1;
      end else begin
        right_sum_nxt = upd.right_sum;
        left_sum_nxt  = upd.left_sum;
        front_sum_nxt = upd.front_sum;
        right_cnt_nxt = upd.right_cnt;
        left_cnt_nxt  = upd.left_cnt;
        front_cnt_nxt = upd.front_cnt;
      end
    end
  end

  // threshold times count per sector
  always_comb begin
    lim.right_lim = srod_pkg::SUM_BITS'(cfg.threshold)
                  * srod_pkg::SUM_BITS'(s1_win_r.right_cnt);
    lim.left_lim  = srod_pkg::SUM_BITS'(cfg.threshold)
                  * srod_pkg::SUM_BITS'(s1_win_r.left_cnt);
    lim.front_lim = srod_pkg::SUM_BITS'(cfg.threshold)
                  * srod_pkg::SUM_BITS'(s1_win_r.front_cnt);
  end

  // mean test, empty sector reads as clear
  always_comb begin
    res.right = (s2_win_r.right_cnt != '0) && (s2_win_r.right_sum <= s2_lim_r.right_lim);
    res.left  = (s2_win_r.left_cnt  != '0) && (s2_win_r.left_sum  <= s2_lim_r.left_lim);
    res.front = (s2_win_r.front_cnt != '0) && (s2_win_r.front_sum <= s2_lim_r.front_lim);
  end

  // result queue
  assign empty     = (q_cnt_r == '0);
  assign flags     = q_r[q_rd_r];
  assign q_pop     = pop && !empty;
  assign q_cnt_nxt = q_cnt_r + srod_pkg::OUT_CNT_BITS'(s2_v_r)
                   - srod_pkg::OUT_CNT_BITS'(q_pop);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      right_sum_r <= '0;
      left_sum_r  <= '0;
      front_sum_r <= '0;
      right_cnt_r <= '0;
      left_cnt_r  <= '0;
      front_cnt_r <= '0;
      s1_v_r      <= 1'b0;
      s2_v_r      <= 1'b0;
      q_wr_r      <= '0;
      q_rd_r      <= '0;
      q_cnt_r     <= '0;
    end else begin
      right_sum_r <= right_sum_nxt;
      left_sum_r  <= left_sum_nxt;
      front_sum_r <= front_sum_nxt;
      right_cnt_r <= right_cnt_nxt;
      left_cnt_r  <= left_cnt_nxt;
      front_cnt_r <= front_cnt_nxt;
      s1_v_r      <= s1_v_nxt;
      s2_v_r      <= s1_v_r;
      q_cnt_r     <= q_cnt_nxt;
      if (s2_v_r) begin
        q_wr_r <= q_wr_r + 1'b1;
      end
      if (q_pop) begin
        q_rd_r <= q_rd_r + 1'b1;
      end
    end
    s1_win_r <= upd;
    s2_win_r <= s1_win_r;
    s2_lim_r <= lim;
    if (s2_v_r) begin
      q_r[q_wr_r] <= res;
    end
  end

  // results in flight never overrun the result queue
  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    committed <= (srod_pkg::OUT_CNT_BITS + 1)'(srod_pkg::OUT_DEPTH))
    else $error("result queue overrun");

  // a captured window always reaches the compare stage next cycle
  a_pipe_flow: assert property (@(posedge clk) disable iff (!rst_n)
    s1_v_r |=> s2_v_r)
    else $error("window capture lost");

  // accumulators start empty right after a window closes
  a_cleared: assert property (@(posedge clk) disable iff (!rst_n)
    s1_v_r |-> (right_cnt_r == '0 && left_cnt_r == '0 && front_cnt_r == '0
                && right_sum_r == '0 && left_sum_r == '0 && front_sum_r == '0))
    else $error("accumulators not cleared at window end");

  // no pop from the middle queue without an item there
  a_pop_valid: assert property (@(posedge clk) disable iff (!rst_n)
    mid_pop |-> mid_valid)
    else $error("pop from empty middle queue");

endmodule

// ===== sv/sector_range_obstacle_detector_unit.sv =====
// ----------------------------------------------------------------------------
// sector_range_obstacle_detector_unit
// sorts range samples into right, front and left sectors and reports obstacles
// ----------------------------------------------------------------------------
// Takes one sample per clock cycle while full is low, with no gaps. The front
// stage classifies the sample by servo angle and passes it through a two-item
// queue to the accumulators, which add one sample per cycle while the result
// queue has room. The last sample of a window passes through the front
// register and the queue, the window closes as the accumulators take it,
// then the threshold-times-count multiply is registered and the compare
// result is written into the four-entry result queue. full rises only when
// the result queue backs up through the pipeline. Configuration registers at
// byte addresses 0, 4, 8 and 12 are front low angle, front high angle, range
// threshold and window size; change them only while no sample is in flight.
module sector_range_obstacle_detector_unit (
  input  logic                                 clk,
  input  logic                                 rst_n,
  // sample input
  input  logic                                 push,
  output logic                                 full,
  input  logic [srod_pkg::ANGLE_BITS-1:0]      in_scan_angle,
  input  logic [srod_pkg::RANGE_BITS-1:0]      in_range_value,
  // result output
  output logic                                 empty,
  input  logic                                 pop,
  output logic                                 out_obstacle_right,
  output logic                                 out_obstacle_left,
  output logic                                 out_obstacle_front,
  // configuration
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic [srod_pkg::CFG_ADDR_BITS-1:0]   paddr,
  input  logic [srod_pkg::CFG_DATA_BITS-1:0]   pwdata,
  output logic [srod_pkg::CFG_DATA_BITS-1:0]   prdata,
  output logic                                 pready
);

  srod_pkg::cfg_t      cfg_r;
  srod_pkg::cfg_t      cfg_nxt;
  srod_pkg::reg_idx_t  reg_idx;
  logic                cfg_wr;
  logic                mid_push;
  logic                mid_full;
  srod_pkg::mid_item_t mid_wr_item;
  logic                mid_valid;
  logic                mid_pop;
  srod_pkg::mid_item_t mid_rd_item;
  srod_pkg::flags_t    flags;

  // register file
  assign pready  = 1'b1;
  assign reg_idx = srod_pkg::reg_idx_t'(paddr[srod_pkg::CFG_ADDR_BITS-1:2]);
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_wr) begin
      unique case (reg_idx)
        srod_pkg::REG_FRONT_LOW:  cfg_nxt.front_low  = pwdata[srod_pkg::ANGLE_BITS-1:0];
        srod_pkg::REG_FRONT_HIGH: cfg_nxt.front_high = pwdata[srod_pkg::ANGLE_BITS-1:0];
        srod_pkg::REG_THRESHOLD:  cfg_nxt.threshold  = pwdata[srod_pkg::THR_BITS-1:0];
        srod_pkg::REG_WINDOW:     cfg_nxt.window     = pwdata[srod_pkg::WIN_BITS-1:0];
        default: begin
        end
      endcase
    end
  end

  // register readback
  always_comb begin
    unique case (reg_idx)
      srod_pkg::REG_FRONT_LOW:  prdata = srod_pkg::CFG_DATA_BITS'(cfg_r.front_low);
      srod_pkg::REG_FRONT_HIGH: prdata = srod_pkg::CFG_DATA_BITS'(cfg_r.front_high);
      srod_pkg::REG_THRESHOLD:  prdata = srod_pkg::CFG_DATA_BITS'(cfg_r.threshold);
      srod_pkg::REG_WINDOW:     prdata = srod_pkg::CFG_DATA_BITS'(cfg_r.window);
      default:                  prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.front_low  <= srod_pkg::FRONT_LOW_RST;
      cfg_r.front_high <= srod_pkg::FRONT_HIGH_RST;
      cfg_r.threshold  <= srod_pkg::THRESHOLD_RST;
      cfg_r.window     <= srod_pkg::WINDOW_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // classification front
  srod_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg         (cfg_r),
    .push        (push),
    .full        (full),
    .scan_angle  (in_scan_angle),
    .range_value (in_range_value),
    .mid_push    (mid_push),
    .mid_full    (mid_full),
    .mid_item    (mid_wr_item)
  );

  // decoupling queue
  srod_mid_fifo u_mid_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (mid_push),
    .wr_item  (mid_wr_item),
    .is_full  (mid_full),
    .rd_en    (mid_pop),
    .rd_valid (mid_valid),
    .rd_item  (mid_rd_item)
  );

  // accumulate and decide
  srod_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .mid_valid (mid_valid),
    .mid_item  (mid_rd_item),
    .mid_pop   (mid_pop),
    .empty     (empty),
    .pop       (pop),
    .flags     (flags)
  );

  assign out_obstacle_right = flags.right;
  assign out_obstacle_left  = flags.left;
  assign out_obstacle_front = flags.front;

endmodule

// ===== tb/sector_range_obstacle_detector_unit_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// sector_range_obstacle_detector_unit_tb
// self-checking bench for the sector range obstacle detector
// ----------------------------------------------------------------------------
// Range samples go in through the queue-style input in random bursts while
// the result side pops on a stall pattern of its own. A behavioral copy of
// the sector sums and counts predicts the flags of every closed window, and
// each popped item is compared field by field with the oldest prediction.
// Registers are written only with the pipeline drained and are read back.
// ----------------------------------------------------------------------------
module sector_range_obstacle_detector_unit_tb;

  localparam int SETTLE_CYCLES  = 12;
  localparam int HOLD_CYCLES    = 300;
  localparam int STALL_LIMIT    = 4000;
  localparam int TARGET_ITEMS   = 950;
  localparam int TARGET_WINDOWS = 60;
  localparam int MAX_REPORTS    = 10;

  typedef enum int {POP_ALWAYS, POP_COIN, POP_SPARSE, POP_MASK} pop_mode_t;

  logic                               clk            = 1'b0;
  logic                               rst_n          = 1'b0;
  logic                               push           = 1'b0;
  logic                               full;
  logic [srod_pkg::ANGLE_BITS-1:0]    in_scan_angle  = '0;
  logic [srod_pkg::RANGE_BITS-1:0]    in_range_value = '0;
  logic                               empty;
  logic                               pop            = 1'b0;
  logic                               out_obstacle_right;
  logic                               out_obstacle_left;
  logic                               out_obstacle_front;
  logic                               psel           = 1'b0;
  logic                               penable        = 1'b0;
  logic                               pwrite         = 1'b0;
  logic [srod_pkg::CFG_ADDR_BITS-1:0] paddr          = '0;
  logic [srod_pkg::CFG_DATA_BITS-1:0] pwdata         = '0;
  logic [srod_pkg::CFG_DATA_BITS-1:0] prdata;
  logic                               pready;

  // predicted configuration and window state
  logic [srod_pkg::ANGLE_BITS-1:0] cfg_low  = srod_pkg::FRONT_LOW_RST;
  logic [srod_pkg::ANGLE_BITS-1:0] cfg_high = srod_pkg::FRONT_HIGH_RST;
  logic [srod_pkg::THR_BITS-1:0]   cfg_thr  = srod_pkg::THRESHOLD_RST;
  logic [srod_pkg::WIN_BITS-1:0]   cfg_win  = srod_pkg::WINDOW_RST;
  logic [srod_pkg::SUM_BITS-1:0]   sector_sum [3];
  logic [srod_pkg::CNT_BITS-1:0]   sector_cnt [3];
  srod_pkg::flags_t                flags_due [$];

  int unsigned items_sent      = 0;
  int unsigned windows_closed  = 0;
  int unsigned results_checked = 0;
  int unsigned mismatches      = 0;
  int unsigned reg_writes      = 0;
  int unsigned full_cycles     = 0;

  // sender burst control
  int unsigned burst_left = 0;
  bit          gaps_on    = 1'b1;

  // receiver stall control
  int unsigned hold_requests = 0;
  int unsigned holds_taken   = 0;
  int unsigned hold_left     = 0;
  int unsigned mode_left     = 0;
  pop_mode_t   pop_mode      = POP_ALWAYS;
  logic [15:0] stall_mask    = 16'hFFFF;

  int unsigned      quiet_cycles = 0;
  srod_pkg::flags_t got_flags;
  srod_pkg::flags_t want_flags;

  sector_range_obstacle_detector_unit u_top (
    .clk                (clk),
    .rst_n              (rst_n),
    .push               (push),
    .full               (full),
    .in_scan_angle      (in_scan_angle),
    .in_range_value     (in_range_value),
    .empty              (empty),
    .pop                (pop),
    .out_obstacle_right (out_obstacle_right),
    .out_obstacle_left  (out_obstacle_left),
    .out_obstacle_front (out_obstacle_front),
    .psel               (psel),
    .penable            (penable),
    .pwrite             (pwrite),
    .paddr              (paddr),
    .pwdata             (pwdata),
    .prdata             (prdata),
    .pready             (pready)
  );

  // clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------------------------------------------------------- predictor

  function automatic void clear_sectors();
    foreach (sector_sum[i]) begin
      sector_sum[i] = '0;
      sector_cnt[i] = '0;
    end
  endfunction

  // empty sector never flags; otherwise mean <= threshold without division
  function automatic logic sector_near(input srod_pkg::sector_t s);
    logic [31:0] limit;
    if (sector_cnt[s] == '0) begin
      return 1'b0;
    end
    limit = 32'(cfg_thr) * 32'(sector_cnt[s]);
    return 32'(sector_sum[s]) <= limit;
  endfunction

  // add one sample to its sector and close the window when it is complete
  function automatic void accumulate_sample(input logic [srod_pkg::ANGLE_BITS-1:0] angle,
                                            input logic [srod_pkg::RANGE_BITS-1:0] rng);
    srod_pkg::sector_t           s;
    logic [srod_pkg::SUM_BITS:0] sum_next;
    int unsigned                 total;
    srod_pkg::flags_t            f;
    if (angle < cfg_low) begin
      s = srod_pkg::SECT_RIGHT;
    end else if (angle <= cfg_high) begin
      s = srod_pkg::SECT_FRONT;
    end else begin
      s = srod_pkg::SECT_LEFT;
    end
    sum_next      = (srod_pkg::SUM_BITS+1)'(sector_sum[s]) + (srod_pkg::SUM_BITS+1)'(rng);
    sector_sum[s] = sum_next[srod_pkg::SUM_BITS] ? {srod_pkg::SUM_BITS{1'b1}}
                                                 : sum_next[srod_pkg::SUM_BITS-1:0];
    sector_cnt[s] = sector_cnt[s] + 1'b1;
    total = 32'(sector_cnt[srod_pkg::SECT_RIGHT]) + 32'(sector_cnt[srod_pkg::SECT_LEFT])
          + 32'(sector_cnt[srod_pkg::SECT_FRONT]);
    if (total >= 32'(cfg_win)) begin
      f.right = sector_near(srod_pkg::SECT_RIGHT);
      f.left  = sector_near(srod_pkg::SECT_LEFT);
      f.front = sector_near(srod_pkg::SECT_FRONT);
      flags_due.push_back(f);
      windows_closed++;
      clear_sectors();
    end
  endfunction

  function automatic logic [srod_pkg::CFG_DATA_BITS-1:0] reg_value(
    input srod_pkg::reg_idx_t idx);
    case (idx)
      srod_pkg::REG_FRONT_LOW:  return srod_pkg::CFG_DATA_BITS'(cfg_low);
      srod_pkg::REG_FRONT_HIGH: return srod_pkg::CFG_DATA_BITS'(cfg_high);
      srod_pkg::REG_THRESHOLD:  return srod_pkg::CFG_DATA_BITS'(cfg_thr);
      default:                  return srod_pkg::CFG_DATA_BITS'(cfg_win);
    endcase
  endfunction

  task automatic log_mismatch(input string msg);
    mismatches++;
    if (mismatches <= MAX_REPORTS) begin
      $display("mismatch: %s", msg);
    end
  endtask

  // ---------------------------------------------------------------- stimulus

  // offer one item and hold it until accepted; bursts end in random gaps
  task automatic send_item(input logic [srod_pkg::ANGLE_BITS-1:0] angle,
                           input logic [srod_pkg::RANGE_BITS-1:0] rng);
    push           <= 1'b1;
    in_scan_angle  <= angle;
    in_range_value <= rng;
    do @(posedge clk); while (full !== 1'b0);
    items_sent++;
    accumulate_sample(angle, rng);
    if (gaps_on) begin
      if (burst_left == 0) begin
        push <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk);
        burst_left = $urandom_range(0, 30);
      end else begin
        burst_left--;
      end
    end
  endtask

  // stop sending, wait for every predicted result, let the pipeline settle
  task automatic wait_until_idle();
    push <= 1'b0;
    while (flags_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // register read back and compared with the predicted value
  task automatic check_reg(input srod_pkg::reg_idx_t idx);
    logic [srod_pkg::CFG_DATA_BITS-1:0] mask;
    logic [srod_pkg::CFG_DATA_BITS-1:0] got;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= srod_pkg::CFG_ADDR_BITS'(4 * int'(idx));
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    got  = prdata;
    mask = (idx == srod_pkg::REG_THRESHOLD) ? srod_pkg::CFG_DATA_BITS'(16'hFFFF)
                                            : srod_pkg::CFG_DATA_BITS'(8'hFF);
    if ((got & mask) !== reg_value(idx)) begin
      log_mismatch($sformatf("register %s read expected %0d got %0d",
                             idx.name(), reg_value(idx), got & mask));
    end
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic write_reg(input srod_pkg::reg_idx_t idx,
                           input logic [srod_pkg::CFG_DATA_BITS-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= srod_pkg::CFG_ADDR_BITS'(4 * int'(idx));
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    case (idx)
      srod_pkg::REG_FRONT_LOW:  cfg_low  = value[srod_pkg::ANGLE_BITS-1:0];
      srod_pkg::REG_FRONT_HIGH: cfg_high = value[srod_pkg::ANGLE_BITS-1:0];
      srod_pkg::REG_THRESHOLD:  cfg_thr  = value[srod_pkg::THR_BITS-1:0];
      default:                  cfg_win  = value[srod_pkg::WIN_BITS-1:0];
    endcase
    reg_writes++;
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
    check_reg(idx);
  endtask

  task automatic set_config(input logic [srod_pkg::CFG_DATA_BITS-1:0] low,
                            input logic [srod_pkg::CFG_DATA_BITS-1:0] high,
                            input logic [srod_pkg::CFG_DATA_BITS-1:0] thr,
                            input logic [srod_pkg::CFG_DATA_BITS-1:0] win);
    wait_until_idle();
    write_reg(srod_pkg::REG_FRONT_LOW, low);
    write_reg(srod_pkg::REG_FRONT_HIGH, high);
    write_reg(srod_pkg::REG_THRESHOLD, thr);
    write_reg(srod_pkg::REG_WINDOW, win);
  endtask

  // junk above the register width now and then; only the low bits count
  function automatic logic [srod_pkg::CFG_DATA_BITS-1:0] with_noise(input int unsigned v,
                                                                    input int w);
    logic [srod_pkg::CFG_DATA_BITS-1:0] junk;
    junk = srod_pkg::CFG_DATA_BITS'($urandom);
    junk = (junk >> w) << w;
    return ($urandom_range(0, 3) == 0) ? (srod_pkg::CFG_DATA_BITS'(v) | junk)
                                       : srod_pkg::CFG_DATA_BITS'(v);
  endfunction

  // angles near the band edges, across the servo span, and past 180
  function automatic logic [srod_pkg::ANGLE_BITS-1:0] pick_angle();
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 25) begin
      case ($urandom_range(0, 3))
        0:       return cfg_low - 1'b1;
        1:       return cfg_low;
        2:       return cfg_high;
        default: return cfg_high + 1'b1;
      endcase
    end
    if (pick < 85) begin
      return srod_pkg::ANGLE_BITS'($urandom_range(0, 180));
    end
    return srod_pkg::ANGLE_BITS'($urandom_range(181, 255));
  endfunction

  // ranges mostly around the threshold so flags go both ways
  function automatic logic [srod_pkg::RANGE_BITS-1:0] pick_range();
    int unsigned pick, span, lo_v, hi_v;
    pick = $urandom_range(0, 99);
    if (pick < 15) begin
      return srod_pkg::RANGE_BITS'($urandom);
    end
    if (pick < 22) begin
      return ($urandom_range(0, 1) != 0) ? '1 : '0;
    end
    span = 32'(cfg_thr) / 4 + 2;
    lo_v = (32'(cfg_thr) > span) ? 32'(cfg_thr) - span : 0;
    hi_v = 32'(cfg_thr) + span;
    if (hi_v > 65535) begin
      hi_v = 65535;
    end
    return srod_pkg::RANGE_BITS'($urandom_range(lo_v, hi_v));
  endfunction

  task automatic apply_random_config();
    int unsigned pick, lo, hi, thr, win;
    pick = $urandom_range(0, 99);
    if (pick < 60) begin
      lo = $urandom_range(0, 180);
      hi = $urandom_range(lo, 180);
    end else if (pick < 75) begin
      lo = 32'(srod_pkg::FRONT_LOW_RST);
      hi = 32'(srod_pkg::FRONT_HIGH_RST);
    end else if (pick < 90) begin
      hi = $urandom_range(0, 170);
      lo = $urandom_range(hi + 1, 180);
    end else begin
      lo = $urandom_range(0, 255);
      hi = $urandom_range(0, 255);
    end
    pick = $urandom_range(0, 99);
    if (pick < 50) begin
      thr = $urandom_range(500, 3000);
    end else if (pick < 70) begin
      thr = $urandom_range(0, 65535);
    end else if (pick < 85) begin
      thr = $urandom_range(0, 50);
    end else begin
      thr = $urandom_range(60000, 65535);
    end
    pick = $urandom_range(0, 99);
    if (pick < 70) begin
      win = $urandom_range(1, 12);
    end else if (pick < 85) begin
      win = $urandom_range(0, 3);
    end else if (pick < 95) begin
      win = $urandom_range(13, 60);
    end else begin
      win = $urandom_range(100, 255);
    end
    set_config(with_noise(lo, srod_pkg::ANGLE_BITS), with_noise(hi, srod_pkg::ANGLE_BITS),
               with_noise(thr, srod_pkg::THR_BITS), with_noise(win, srod_pkg::WIN_BITS));
  endtask

  // ---------------------------------------------------------------- tests

  task automatic test_reset_values();
    check_reg(srod_pkg::REG_FRONT_LOW);
    check_reg(srod_pkg::REG_FRONT_HIGH);
    check_reg(srod_pkg::REG_THRESHOLD);
    check_reg(srod_pkg::REG_WINDOW);
  endtask

  // samples on both sides of each band edge, range extremes, angles past 180
  task automatic test_sector_edges();
    set_config(95, 105, 1000, 4);
    send_item(8'd94, 16'd1000);
    send_item(8'd95, 16'd1001);
    send_item(8'd105, 16'd0);
    send_item(8'd106, 16'hFFFF);
    send_item(8'd0, 16'd0);
    send_item(8'd180, 16'd1000);
    send_item(8'd255, 16'd999);
    send_item(8'd181, 16'd1001);
  endtask

  // right and left sectors stay empty
  task automatic test_empty_sectors();
    set_config(95, 105, 1000, 2);
    send_item(8'd100, 16'd5);
    send_item(8'd100, 16'd2000);
  endtask

  task automatic test_threshold_extremes();
    set_config(95, 105, 0, 1);
    send_item(8'd50, 16'd0);
    send_item(8'd50, 16'd1);
    set_config(95, 105, 16'hFFFF, 1);
    send_item(8'd150, 16'hFFFF);
  endtask

  // low bound above high bound, then a band over every angle
  task automatic test_band_extremes();
    set_config(120, 60, 500, 3);
    send_item(8'd30, 16'd400);
    send_item(8'd119, 16'd600);
    send_item(8'd120, 16'd500);
    set_config(0, 255, 700, 2);
    send_item(8'd0, 16'd700);
    send_item(8'd255, 16'd701);
  endtask

  // window of zero closes after every sample
  task automatic test_window_zero();
    set_config(95, 105, 1000, 0);
    send_item(8'd10, 16'd1000);
    send_item(8'd100, 16'd1001);
    send_item(8'd170, 16'd3);
  endtask

  // window shrunk below the samples already held closes on the next one
  task automatic test_window_lowered();
    set_config(95, 105, 1000, 255);
    send_item(8'd20, 16'd900);
    send_item(8'd100, 16'd1100);
    send_item(8'd160, 16'd1000);
    set_config(95, 105, 1000, 2);
    send_item(8'd40, 16'd1200);
  endtask

  // receiver holds off while samples keep coming, so the block fills
  task automatic test_backpressure();
    set_config(95, 105, 1000, 0);
    gaps_on = 1'b0;
    hold_requests <= hold_requests + 1;
    repeat (40) send_item(pick_angle(), pick_range());
    gaps_on = 1'b1;
    wait_until_idle();
  endtask

  // sender pauses mid-stream until every result is out
  task automatic test_sender_pause();
    apply_random_config();
    repeat (30) send_item(pick_angle(), pick_range());
    wait_until_idle();
    repeat (30) send_item(pick_angle(), pick_range());
  endtask

  task automatic test_random_traffic();
    int unsigned n;
    while (items_sent < TARGET_ITEMS || windows_closed < TARGET_WINDOWS) begin
      apply_random_config();
      gaps_on = ($urandom_range(0, 4) != 0);
      n = $urandom_range(20, 80);
      repeat (n) send_item(pick_angle(), pick_range());
    end
    gaps_on = 1'b1;
  endtask

  // ---------------------------------------------------------------- receiver

  // pop pattern changes mode every so often; a hold request blocks it fully
  always @(posedge clk) begin
    if (hold_requests != holds_taken) begin
      holds_taken++;
      hold_left = HOLD_CYCLES;
    end
    if (mode_left == 0) begin
      pop_mode   = pop_mode_t'($urandom_range(0, 3));
      mode_left  = $urandom_range(16, 200);
      stall_mask = 16'($urandom);
    end
    mode_left--;
    stall_mask = {stall_mask[14:0], stall_mask[15]};
    if (hold_left != 0) begin
      hold_left--;
      pop <= 1'b0;
    end else begin
      case (pop_mode)
        POP_ALWAYS: pop <= 1'b1;
        POP_COIN:   pop <= ($urandom_range(0, 1) != 0);
        POP_SPARSE: pop <= ($urandom_range(0, 3) == 0);
        default:    pop <= stall_mask[0];
      endcase
    end
  end

  // compare each popped item with the oldest prediction
  always @(posedge clk) begin
    if (rst_n && pop && empty === 1'b0) begin
      results_checked++;
      got_flags.right = out_obstacle_right;
      got_flags.left  = out_obstacle_left;
      got_flags.front = out_obstacle_front;
      if (flags_due.size() == 0) begin
        log_mismatch($sformatf("unexpected result right=%b left=%b front=%b",
                               got_flags.right, got_flags.left, got_flags.front));
      end else begin
        want_flags = flags_due.pop_front();
        if (got_flags.right !== want_flags.right || got_flags.left !== want_flags.left ||
            got_flags.front !== want_flags.front) begin
          log_mismatch($sformatf(
            "result %0d right/left/front expected %b/%b/%b got %b/%b/%b",
            results_checked, want_flags.right, want_flags.left, want_flags.front,
            got_flags.right, got_flags.left, got_flags.front));
        end
      end
    end
  end

  // watchdog on cycles with no handshake of any kind
  always @(posedge clk) begin
    if (!rst_n || (push && full === 1'b0) || (pop && empty === 1'b0) || psel) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (full === 1'b1) begin
      full_cycles++;
    end
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("watchdog: no progress for %0d cycles", STALL_LIMIT);
      $display("[sector_range_obstacle_detector_unit] ERROR");
      $finish;
    end
  end

  // ---------------------------------------------------------------- sequence

  initial begin
    clear_sectors();
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_values();
    test_sector_edges();
    test_empty_sectors();
    test_threshold_extremes();
    test_band_extremes();
    test_window_zero();
    test_window_lowered();
    test_backpressure();
    test_sender_pause();
    test_random_traffic();
    wait_until_idle();
    $display("run: %0d samples, %0d windows predicted, %0d results checked, %0d reg writes",
             items_sent, windows_closed, results_checked, reg_writes);
    $display("run: band edges, empty sectors, inverted band, zero and shrunk windows, %0d %s",
             full_cycles, "cycles with input stalled");
    if (mismatches == 0 && flags_due.size() == 0) begin
      $display("[sector_range_obstacle_detector_unit] OK");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("[sector_range_obstacle_detector_unit] ERROR");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
sv/srod_pkg.sv
sv/srod_front.sv
sv/srod_mid_fifo.sv
sv/srod_back.sv
sv/sector_range_obstacle_detector_unit.sv
tb/sector_range_obstacle_detector_unit_tb.sv
